[rtl/lsmh_pkg.sv]
`default_nettype none

package lsmh_pkg;

    localparam int DUR_W = 31;
    localparam int OUT_W = 48;
    localparam int MOD_W = 30;
    localparam int MC_W  = 7;

    localparam logic [MOD_W-1:0] MOD_PRIME = 30'd1000000007;

    typedef struct packed {
        logic [DUR_W-1:0] task_duration;
        logic             last_task;
    } s_data_t;

    typedef struct packed {
        logic [OUT_W-1:0] start_time;
        logic [OUT_W-1:0] finish_time;
        logic [OUT_W-1:0] makespan;
        logic [MOD_W-1:0] makespan_mod;
        logic             batch_done;
    } m_data_t;

    typedef struct packed {
        logic clear;
        logic update;
    } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/lsmh_cell.sv]
`default_nettype none

module lsmh_cell #(
    parameter int W = 48
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire lsmh_pkg::cell_ctl_t ctl,
    input  wire logic [W-1:0]        finish_i,
    input  wire logic                lead_i,
    input  wire logic                active_i,
    input  wire logic                nbr_active_i,
    input  wire logic [W-1:0]        nbr_value_i,
    output logic      [W-1:0]        value_o
);
    import lsmh_pkg::*;

    logic [W-1:0] value_reg;
    logic [W-1:0] value_next;

    // remove the head, insert finish in sorted position
    always_comb begin
        value_next = value_reg;
        if (ctl.clear) begin
            value_next = '0;
        end else if (ctl.update && active_i) begin
            if (nbr_active_i && (nbr_value_i < finish_i)) begin
                value_next = nbr_value_i;
            end else if (lead_i || (value_reg < finish_i)) begin
                value_next = finish_i;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
        end else begin
            value_reg <= value_next;
        end
    end

    assign value_o = value_reg;

endmodule

`default_nettype wire

[rtl/lsmh_mod.sv]
`default_nettype none

module lsmh_mod #(
    parameter int W = 48
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start_i,
    input  wire logic [W-1:0]               value_i,
    output logic                            done_o,
    output logic [lsmh_pkg::MOD_W-1:0]      rem_o
);
    import lsmh_pkg::*;

    localparam int CH_W   = 18;
    localparam int NCH    = (W + CH_W - 1) / CH_W;
    localparam int PAD_W  = NCH * CH_W;
    localparam int CNT_W  = $clog2(NCH + 1);
    localparam int T_W    = MOD_W + CH_W;
    localparam int HI_LSB = 29;
    localparam int HI_W   = T_W - HI_LSB;
    localparam int RCP_W  = HI_W + 1;
    localparam int QP_W   = HI_W + RCP_W;
    localparam int PP_W   = HI_W + MOD_W;
    localparam int EST_W  = MOD_W + 2;

    // floor(2^(HI_LSB + RCP_W) / MOD_PRIME)
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'((64'd1 << (HI_LSB + RCP_W)) / 64'(MOD_PRIME));
    localparam logic [EST_W-1:0] P1 = EST_W'(MOD_PRIME);
    localparam logic [EST_W-1:0] P2 = EST_W'(MOD_PRIME) << 1;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_QUOT = 2'd1;
    localparam logic [1:0] PH_EST  = 2'd2;
    localparam logic [1:0] PH_FIX  = 2'd3;

    logic [1:0]          phase_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [PAD_W-1:0]    val_reg;
    logic [T_W-1:0]      t_reg;
    logic [HI_W-1:0]     q_reg;
    logic [EST_W-1:0]    est_reg;
    logic [MOD_W-1:0]    rem_reg;
    logic [PAD_W-1:0]    val_pad;
    logic [QP_W-1:0]     q_prod;
    logic [PP_W-1:0]     qp_prod;
    logic [MOD_W-1:0]    rem_fix;

    assign val_pad = PAD_W'(value_i);
    assign q_prod  = QP_W'(t_reg[T_W-1:HI_LSB]) * QP_W'(RECIP);
    assign qp_prod = PP_W'(q_reg) * PP_W'(MOD_PRIME);

    // estimate is below three times the prime
    always_comb begin
        if (est_reg >= P2) begin
            rem_fix = MOD_W'(est_reg - P2);
        end else if (est_reg >= P1) begin
            rem_fix = MOD_W'(est_reg - P1);
        end else begin
            rem_fix = est_reg[MOD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= (phase_reg == PH_FIX) && (cnt_reg == CNT_W'(1));
            unique case (phase_reg)
                PH_IDLE: begin
                    if (start_i) begin
                        phase_reg <= PH_QUOT;
                        cnt_reg   <= CNT_W'(NCH);
                    end
                end
                PH_QUOT: begin
                    phase_reg <= PH_EST;
                end
                PH_EST: begin
                    phase_reg <= PH_FIX;
                end
                PH_FIX: begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) begin
                        phase_reg <= PH_IDLE;
                    end else begin
                        phase_reg <= PH_QUOT;
                    end
                end
                default: begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    // fold one chunk a pass: remainder of {rem, chunk} by reciprocal estimate
    always_ff @(posedge aclk) begin
        case (phase_reg)
            PH_IDLE: begin
                if (start_i) begin
                    t_reg   <= {{MOD_W{1'b0}}, val_pad[PAD_W-1 -: CH_W]};
                    val_reg <= val_pad << CH_W;
                end
            end
            PH_QUOT: begin
                q_reg <= q_prod[QP_W-1 -: HI_W];
            end
            PH_EST: begin
                est_reg <= t_reg[EST_W-1:0] - qp_prod[EST_W-1:0];
            end
            PH_FIX: begin
                rem_reg <= rem_fix;
                t_reg   <= {rem_fix, val_reg[PAD_W-1 -: CH_W]};
                val_reg <= val_reg << CH_W;
            end
            default: begin
            end
        endcase
    end

    assign done_o = done_reg;
    assign rem_o  = rem_reg;

endmodule

`default_nettype wire

[rtl/list_scheduler_min_heap.sv]
`default_nettype none
// Channel  Handshake               Payload
// s_       s_valid / s_ready       s_data   (task_duration, last_task)
// m_       m_valid / m_ready       m_data   (start, finish, makespan, mod, batch_done)
// cfg_     cfg_valid / cfg_ready   cfg_data (machine_count)
// An item passes through accept, saturating add on the head cell, one
// shift-insert step across the cell row, and the output register load.
// An item flagged last also waits for the modulo, which folds ceil(TIME_BITS / 18) chunks.
// Reset and a machine_count write clear the cell row and makespan.
// A new item is taken while the previous result waits in the output register;
// hold in the final state while that register is still full.

module list_scheduler_min_heap #(
    parameter int MAX_MACHINES = 64,
    parameter int TIME_BITS    = 48
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire lsmh_pkg::s_data_t          s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output lsmh_pkg::m_data_t               m_data,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [lsmh_pkg::MC_W-1:0]  cfg_data
);
    import lsmh_pkg::*;

    localparam int CNT_W = $clog2(MAX_MACHINES + 1);
    localparam int CMP_W = (CNT_W > MC_W) ? CNT_W : MC_W;
    localparam int EXT_W = (TIME_BITS > OUT_W) ? TIME_BITS : OUT_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ADD  = 3'd1;
    localparam logic [2:0] ST_UPD  = 3'd2;
    localparam logic [2:0] ST_MOD  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]           state_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [DUR_W-1:0]     dur_reg;
    logic                 last_reg;
    logic [TIME_BITS-1:0] start_reg;
    logic [TIME_BITS-1:0] finish_reg;
    logic [TIME_BITS-1:0] mk_reg;
    logic [TIME_BITS-1:0] mk_next;
    logic [MOD_W-1:0]     mod_rem;
    logic                 mod_done;
    logic                 mod_start;
    logic                 m_valid_reg;
    m_data_t              m_data_reg;

    logic [TIME_BITS-1:0] cell_val [0:MAX_MACHINES];
    logic [MAX_MACHINES:0] cell_act;
    cell_ctl_t            ctl;

    logic [TIME_BITS:0]   sum;
    logic [TIME_BITS-1:0] finish_sat;
    logic [CMP_W-1:0]     mc_ext;
    logic [CNT_W-1:0]     n_next;
    logic                 s_fire;
    logic                 cfg_fire;
    logic                 out_free;
    logic [EXT_W-1:0]     start_ext;
    logic [EXT_W-1:0]     finish_ext;
    logic [EXT_W-1:0]     mk_ext;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign sum        = {1'b0, cell_val[0]} + (TIME_BITS + 1)'(dur_reg);
    assign finish_sat = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
    assign mk_next    = (finish_reg > mk_reg) ? finish_reg : mk_reg;

    always_comb begin
        mc_ext = CMP_W'(cfg_data);
        if (mc_ext == '0) begin
            n_next = CNT_W'(1);
        end else if (mc_ext > CMP_W'(MAX_MACHINES)) begin
            n_next = CNT_W'(MAX_MACHINES);
        end else begin
            n_next = mc_ext[CNT_W-1:0];
        end
    end

    assign ctl.update = (state_reg == ST_UPD);
    assign ctl.clear  = cfg_fire || ((state_reg == ST_FIN) && out_free && last_reg);
    assign mod_start  = (state_reg == ST_UPD) && last_reg;

    assign cell_val[MAX_MACHINES] = '0;
    assign cell_act[MAX_MACHINES] = 1'b0;

    for (genvar i = 0; i < MAX_MACHINES; i++) begin : g_cell
        assign cell_act[i] = (CNT_W'(i) < n_reg);

        lsmh_cell #(
            .W(TIME_BITS)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctl          (ctl),
            .finish_i     (finish_reg),
            .lead_i       (i == 0),
            .active_i     (cell_act[i]),
            .nbr_active_i (cell_act[i+1]),
            .nbr_value_i  (cell_val[i+1]),
            .value_o      (cell_val[i])
        );
    end

    lsmh_mod #(
        .W(TIME_BITS)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (mod_start),
        .value_i (mk_next),
        .done_o  (mod_done),
        .rem_o   (mod_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            n_reg       <= CNT_W'(1);
            mk_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_FIN)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (cfg_fire) begin
                        n_reg  <= n_next;
                        mk_reg <= '0;
                    end
                    if (s_fire) begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    state_reg <= ST_UPD;
                end
                ST_UPD: begin
                    mk_reg    <= mk_next;
                    state_reg <= last_reg ? ST_MOD : ST_FIN;
                end
                ST_MOD: begin
                    if (mod_done) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                        if (last_reg) begin
                            mk_reg <= '0;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            dur_reg  <= s_data.task_duration;
            last_reg <= s_data.last_task;
        end
        if (state_reg == ST_ADD) begin
            start_reg  <= cell_val[0];
            finish_reg <= finish_sat;
        end
    end

    assign start_ext  = EXT_W'(start_reg);
    assign finish_ext = EXT_W'(finish_reg);
    assign mk_ext     = EXT_W'(mk_reg);

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_FIN) && out_free) begin
            m_data_reg.start_time   <= start_ext[OUT_W-1:0];
            m_data_reg.finish_time  <= finish_ext[OUT_W-1:0];
            m_data_reg.makespan     <= mk_ext[OUT_W-1:0];
            m_data_reg.makespan_mod <= last_reg ? mod_rem : '0;
            m_data_reg.batch_done   <= last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`default_nettype none

module tb_top;
    import lsmh_pkg::*;

    localparam logic [OUT_W-1:0] TIME_MAX   = '1;
    localparam logic [DUR_W-1:0] DUR_MAX    = '1;
    localparam int               HEAP_DEPTH = 64;
    localparam int               TAIL_WAIT  = 64;
    localparam int               RUN_LIMIT  = 12 * 1_000_000;

    typedef enum logic {ROW_TASK, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t       kind;
        s_data_t         job;
        logic [MC_W-1:0] count;
        logic            typed;
        m_data_t         want;
    } row_t;

    logic            aclk      = 1'b0;
    logic            aresetn   = 1'b0;
    logic            s_valid   = 1'b0;
    logic            s_ready;
    s_data_t         s_data    = '0;
    logic            m_valid;
    logic            m_ready   = 1'b0;
    m_data_t         m_data;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [MC_W-1:0] cfg_data  = '0;

    logic [OUT_W-1:0] free_at [HEAP_DEPTH];
    logic [OUT_W-1:0] span_now;
    logic [MC_W-1:0]  machines;
    m_data_t          schedule_q [$];
    row_t             plan [$];
    int               mismatches    = 0;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;

    always #6 aclk = ~aclk;

    list_scheduler_min_heap dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    function automatic void clear_machines();
        for (int i = 0; i < HEAP_DEPTH; i++) begin
            free_at[i] = '0;
        end
        span_now = '0;
    endfunction

    function automatic void set_machines(logic [MC_W-1:0] v);
        machines = v;
        clear_machines();
    endfunction

    function automatic m_data_t assign_task(s_data_t t);
        int               n;
        int               pos;
        int               best;
        int               l;
        int               r;
        bit               settled;
        logic [OUT_W:0]   sum;
        logic [OUT_W-1:0] hold;
        logic [OUT_W-1:0] rem;
        m_data_t          res;
        n = (machines == 0) ? 1 : (machines > HEAP_DEPTH) ? HEAP_DEPTH : int'(machines);
        sum = {1'b0, free_at[0]} + (OUT_W + 1)'(t.task_duration);
        res.start_time  = free_at[0];
        res.finish_time = sum[OUT_W] ? TIME_MAX : sum[OUT_W-1:0];
        if (res.finish_time > span_now) begin
            span_now = res.finish_time;
        end
        free_at[0] = res.finish_time;
        pos = 0;
        settled = 1'b0;
        while (!settled) begin
            best = pos;
            l = 2 * pos + 1;
            r = 2 * pos + 2;
            if (l < n && free_at[l] < free_at[best]) begin
                best = l;
            end
            if (r < n && free_at[r] < free_at[best]) begin
                best = r;
            end
            if (best == pos) begin
                settled = 1'b1;
            end else begin
                hold = free_at[pos];
                free_at[pos] = free_at[best];
                free_at[best] = hold;
                pos = best;
            end
        end
        rem = span_now % {{(OUT_W-MOD_W){1'b0}}, MOD_PRIME};
        res.makespan     = span_now;
        res.makespan_mod = t.last_task ? rem[MOD_W-1:0] : '0;
        res.batch_done   = t.last_task;
        if (t.last_task) begin
            clear_machines();
        end
        return res;
    endfunction

    function automatic void plan_job(logic [DUR_W-1:0] dur, logic last, logic typed,
                                     logic [OUT_W-1:0] st, logic [OUT_W-1:0] fin,
                                     logic [OUT_W-1:0] span, logic [MOD_W-1:0] md);
        row_t row;
        row.kind  = ROW_TASK;
        row.job   = {dur, last};
        row.count = '0;
        row.typed = typed;
        row.want  = {st, fin, span, md, last};
        plan.push_back(row);
    endfunction

    function automatic void plan_cfg(logic [MC_W-1:0] v);
        row_t row;
        row = '0;
        row.kind  = ROW_CFG;
        row.count = v;
        plan.push_back(row);
    endfunction

    function automatic logic [DUR_W-1:0] pick_duration(int style, logic [DUR_W-1:0] fixed);
        logic [31:0] raw;
        raw = $urandom();
        case (style)
            0: return raw[DUR_W-1:0];
            1: return DUR_W'(raw[2:0]);
            2: begin
                case (raw[1:0])
                    2'd0: return '0;
                    2'd1: return DUR_MAX;
                    2'd2: return DUR_W'($urandom_range(1000));
                    default: return raw[DUR_W+0:1];
                endcase
            end
            default: return fixed;
        endcase
    endfunction

    function automatic logic [MC_W-1:0] pick_count();
        case ($urandom_range(7))
            0: return MC_W'(0);
            1: return MC_W'(1);
            2: return MC_W'(64);
            3: return MC_W'(127);
            4: return MC_W'($urandom_range(65, 126));
            default: return MC_W'($urandom_range(2, 63));
        endcase
    endfunction

    task automatic drain();
        if (s_valid) begin
            s_valid <= 1'b0;
        end
        while (schedule_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_machines(input logic [MC_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        set_machines(v);
    endtask

    task automatic send_job(input s_data_t d, input logic typed, input m_data_t want);
        m_data_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predicted = assign_task(d);
        schedule_q.push_back(typed ? want : predicted);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int jobs);
        int               sent;
        int               len;
        int               style;
        logic [DUR_W-1:0] fixed;
        s_data_t          d;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < jobs) begin
            if ($urandom_range(3) == 0) begin
                write_machines(pick_count());
            end
            len = ($urandom_range(7) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 24);
            style = $urandom_range(3);
            fixed = pick_duration(0, '0);
            for (int i = 0; i < len; i++) begin
                if (i > 0 && $urandom_range(39) == 0) begin
                    write_machines(pick_count());
                end else if ($urandom_range(59) == 0) begin
                    drain();
                end
                d.task_duration = pick_duration(style, fixed);
                d.last_task     = (i == len - 1);
                send_job(d, 1'b0, '0);
            end
            sent += len;
        end
    endtask

    task automatic report(input string what, input logic [OUT_W-1:0] want,
                          input logic [OUT_W-1:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s mismatch: expected %0d, got %0d", what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin : check_results
        m_data_t want;
        if (aresetn && m_valid && m_ready) begin
            if (schedule_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: start %0d finish %0d makespan %0d",
                             m_data.start_time, m_data.finish_time, m_data.makespan);
                end
            end else begin
                want = schedule_q.pop_front();
                if (m_data.start_time !== want.start_time) begin
                    report("start_time", want.start_time, m_data.start_time);
                end
                if (m_data.finish_time !== want.finish_time) begin
                    report("finish_time", want.finish_time, m_data.finish_time);
                end
                if (m_data.makespan !== want.makespan) begin
                    report("makespan", want.makespan, m_data.makespan);
                end
                if (m_data.makespan_mod !== want.makespan_mod) begin
                    report("makespan_mod", OUT_W'(want.makespan_mod),
                           OUT_W'(m_data.makespan_mod));
                end
                if (m_data.batch_done !== want.batch_done) begin
                    report("batch_done", OUT_W'(want.batch_done),
                           OUT_W'(m_data.batch_done));
                end
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        set_machines(1);

        // one machine after reset
        plan_job(0, 0, 1, 0, 0, 0, 0);
        plan_job(5, 0, 1, 0, 5, 5, 0);
        plan_job(7, 1, 1, 5, 12, 12, 12);
        plan_job(DUR_MAX, 0, 1, 0, 48'd2147483647, 48'd2147483647, 0);
        plan_job(DUR_MAX, 1, 1, 48'd2147483647, 48'd4294967294, 48'd4294967294,
                 30'd294967266);
        // four machines, equal free times
        plan_cfg(4);
        plan_job(10, 0, 1, 0, 10, 10, 0);
        plan_job(10, 0, 1, 0, 10, 10, 0);
        plan_job(10, 0, 1, 0, 10, 10, 0);
        plan_job(10, 0, 1, 0, 10, 10, 0);
        plan_job(3, 0, 1, 10, 13, 13, 0);
        plan_job(0, 1, 1, 10, 10, 13, 13);
        // register write in the middle of a batch
        plan_job(20, 0, 1, 0, 20, 20, 0);
        plan_cfg(2);
        plan_job(1, 1, 1, 0, 1, 1, 1);
        // zero count acts as one machine
        plan_cfg(0);
        plan_job(4, 0, 1, 0, 4, 4, 0);
        plan_job(6, 1, 1, 4, 10, 10, 10);
        // counts at and above the heap depth
        plan_cfg(127);
        plan_job(9, 0, 0, 0, 0, 0, 0);
        plan_job(9, 0, 0, 0, 0, 0, 0);
        plan_job(2, 0, 0, 0, 0, 0, 0);
        plan_job(DUR_MAX, 1, 0, 0, 0, 0, 0);
        plan_cfg(64);
        plan_job(1, 0, 0, 0, 0, 0, 0);
        plan_job(0, 1, 0, 0, 0, 0, 0);
        plan_cfg(65);
        plan_job(3, 1, 0, 0, 0, 0, 0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 32;
        recv_idle_pct = 52;
        for (int k = 0; k < plan.size(); k++) begin
            if (plan[k].kind == ROW_CFG) begin
                write_machines(plan[k].count);
            end else begin
                send_job(plan[k].job, plan[k].typed, plan[k].want);
            end
        end

        run_phase(32, 52, 625);
        run_phase(52, 32, 625);
        run_phase(0, 0, 625);

        drain();
        repeat (TAIL_WAIT) @(posedge aclk);
        if (mismatches == 0 && schedule_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/lsmh_pkg.sv
rtl/lsmh_cell.sv
rtl/lsmh_mod.sv
rtl/list_scheduler_min_heap.sv
tb/sv/tb_top.sv
